FILE: hw/rtl/shkp_pkg.sv
// Shared types and constants of the ServerHello key share parser.
package shkp_pkg;

    localparam logic [7:0]  HELLO_TYPE     = 8'h02;
    localparam logic [15:0] KEY_SHARE_TYPE = 16'h0033;
    localparam logic [5:0]  MIN_SHARE_LEN  = 6'd36;
    localparam logic [15:0] MIN_BODY_LEN   = 16'd38;
    localparam logic [15:0] SID_LEN_OFFSET = 16'd38;   // 4 + 2 + 32
    localparam int          KEY_BYTES      = 32;
    localparam int          KEY_IDX_W      = $clog2(KEY_BYTES);
    localparam int          Q_DEPTH        = 2;
    localparam int          Q_PTR_W        = $clog2(Q_DEPTH);

    // Byte classes handed from front to back
    localparam logic [1:0] CLS_SKIP    = 2'd0;
    localparam logic [1:0] CLS_AREA_HI = 2'd1;
    localparam logic [1:0] CLS_AREA_LO = 2'd2;
    localparam logic [1:0] CLS_EXT     = 2'd3;

    localparam logic [1:0] STATUS_FOUND  = 2'd0;
    localparam logic [1:0] STATUS_BAD    = 2'd1;
    localparam logic [1:0] STATUS_NO_KEY = 2'd2;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] cls;
        logic       mal;    // record malformed, meaningful on last
    } q_entry_t;

    typedef struct packed {
        logic [7:0]           key_byte;
        logic [KEY_IDX_W-1:0] key_index;
        logic                 key_valid;
        logic                 done_res;
        logic [1:0]           status;
    } result_t;

endpackage

FILE: hw/rtl/shkp_front.sv
// Front end: walks the fixed hello header and tags each byte with a class.
module shkp_front import shkp_pkg::*; #(
    parameter int MAX_BODY_BYTES = 32768
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output q_entry_t   entry
);

    localparam logic [2:0] PH_FIXED   = 3'd0;
    localparam logic [2:0] PH_SIDLEN  = 3'd1;
    localparam logic [2:0] PH_SID     = 3'd2;
    localparam logic [2:0] PH_SUITE   = 3'd3;
    localparam logic [2:0] PH_AREA_HI = 3'd4;
    localparam logic [2:0] PH_AREA_LO = 3'd5;
    localparam logic [2:0] PH_EXT     = 3'd6;
    localparam logic [2:0] PH_IDLE    = 3'd7;

    localparam logic [16:0] MaxBody = 17'(MAX_BODY_BYTES);

    logic [15:0] offset_reg, offset_next;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  count_reg, count_next;
    logic        bad_reg, bad_next;
    logic        oversize;
    logic [2:0]  phase_eff;
    logic [7:0]  count_dec;
    logic [1:0]  cls;

    assign oversize  = {1'b0, offset_reg} >= MaxBody;
    assign phase_eff = oversize ? PH_IDLE : phase_reg;
    assign count_dec = count_reg - 8'd1;

    always_comb begin
        phase_next = phase_eff;
        count_next = count_reg;
        bad_next   = bad_reg | oversize;
        cls        = CLS_SKIP;
        unique case (phase_eff)
            PH_FIXED: begin
                if (offset_reg == 16'd0 && data_byte != HELLO_TYPE) begin
                    bad_next   = 1'b1;
                    phase_next = PH_IDLE;
                end else if (offset_reg == SID_LEN_OFFSET - 16'd1) begin
                    phase_next = PH_SIDLEN;
                end
            end
            PH_SIDLEN: begin
                if (data_byte == 8'd0) begin
                    count_next = 8'd3;
                    phase_next = PH_SUITE;
                end else begin
                    count_next = data_byte;
                    phase_next = PH_SID;
                end
            end
            PH_SID: begin
                count_next = count_dec;
                if (count_dec == 8'd0) begin
                    count_next = 8'd3;
                    phase_next = PH_SUITE;
                end
            end
            PH_SUITE: begin
                count_next = count_dec;
                if (count_dec == 8'd0) phase_next = PH_AREA_HI;
            end
            PH_AREA_HI: begin
                cls        = CLS_AREA_HI;
                phase_next = PH_AREA_LO;
            end
            PH_AREA_LO: begin
                cls        = CLS_AREA_LO;
                phase_next = PH_EXT;
            end
            PH_EXT: begin
                cls = CLS_EXT;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
        offset_next = offset_reg;
        if (offset_reg != 16'hFFFF) offset_next = offset_reg + 16'd1;
    end

    assign entry.data = data_byte;
    assign entry.last = last_byte;
    assign entry.cls  = cls;
    // 17-bit compare so a saturated offset does not wrap to a short body
    assign entry.mal  = bad_next ||
                        (({1'b0, offset_reg} + 17'd1) < {1'b0, MIN_BODY_LEN});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            phase_reg  <= PH_FIXED;
            count_reg  <= '0;
            bad_reg    <= 1'b0;
        end else if (push) begin
            if (last_byte) begin
                offset_reg <= '0;
                phase_reg  <= PH_FIXED;
                count_reg  <= '0;
                bad_reg    <= 1'b0;
            end else begin
                offset_reg <= offset_next;
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                bad_reg    <= bad_next;
            end
        end
    end

endmodule

FILE: hw/rtl/shkp_queue.sv
// Short queue of classified bytes between front and back.
module shkp_queue import shkp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output q_entry_t head
);

    q_entry_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_PTR_W:0]     count_reg;

    assign full      = count_reg == (Q_PTR_W+1)'(Q_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            if (push && !pop)      count_reg <= count_reg + (Q_PTR_W+1)'(1);
            else if (pop && !push) count_reg <= count_reg - (Q_PTR_W+1)'(1);
        end
    end

endmodule

FILE: hw/rtl/shkp_back.sv
// Back end: walks the extension list, emits key bytes and the final status.
module shkp_back import shkp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    input  q_entry_t entry,
    output logic     pop,
    output logic     out_valid,
    input  logic     out_ready,
    output result_t  result
);

    localparam logic [1:0] BP_WAIT = 2'd0;
    localparam logic [1:0] BP_HDR  = 2'd1;
    localparam logic [1:0] BP_BODY = 2'd2;
    localparam logic [1:0] BP_IDLE = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [5:0]  count_reg, count_next;
    logic [15:0] area_reg, area_next;
    logic [15:0] type_reg, type_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] klen_reg, klen_next;
    logic        found_reg, found_next;
    logic        out_vld_reg;
    result_t     res_reg, res_next;
    logic [15:0] area_dec;
    logic [15:0] left_dec;
    logic [5:0]  kidx;
    logic        share_hit;

    assign pop       = in_valid && (!out_vld_reg || out_ready);
    assign out_valid = out_vld_reg;
    assign result    = res_reg;

    assign area_dec  = (area_reg != 16'd0) ? area_reg - 16'd1 : area_reg;
    assign left_dec  = left_reg - 16'd1;
    assign kidx      = count_reg - 6'd4;
    assign share_hit = type_reg == KEY_SHARE_TYPE && count_reg < MIN_SHARE_LEN &&
                       ({1'b0, left_reg} + 17'(count_reg) >= 17'(MIN_SHARE_LEN));

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        area_next  = area_reg;
        type_next  = type_reg;
        left_next  = left_reg;
        klen_next  = klen_reg;
        found_next = found_reg;
        res_next   = '0;
        unique case (entry.cls)
            CLS_AREA_HI: area_next = {entry.data, 8'h00};
            CLS_AREA_LO: begin
                area_next  = {area_reg[15:8], entry.data};
                count_next = '0;
                phase_next = (area_next >= 16'd4) ? BP_HDR : BP_IDLE;
            end
            CLS_EXT: begin
                unique case (phase_reg)
                    BP_HDR: begin
                        area_next = area_dec;
                        unique case (count_reg[1:0])
                            2'd0:    type_next = {entry.data, 8'h00};
                            2'd1:    type_next = {type_reg[15:8], entry.data};
                            2'd2:    left_next = {entry.data, 8'h00};
                            default: left_next = {left_reg[15:8], entry.data};
                        endcase
                        if (count_reg[1:0] == 2'd3) begin
                            count_next = '0;
                            if (left_next == 16'd0)
                                phase_next = (area_dec >= 16'd4) ? BP_HDR : BP_IDLE;
                            else
                                phase_next = BP_BODY;
                        end else begin
                            count_next = count_reg + 6'd1;
                        end
                    end
                    BP_BODY: begin
                        area_next = area_dec;
                        if (share_hit) begin
                            if (count_reg == 6'd2) begin
                                klen_next = {entry.data, 8'h00};
                            end else if (count_reg == 6'd3) begin
                                klen_next = {klen_reg[15:8], entry.data};
                            end else if (count_reg >= 6'd4 &&
                                         klen_reg == 16'(KEY_BYTES)) begin
                                res_next.key_byte  = entry.data;
                                res_next.key_index = kidx[KEY_IDX_W-1:0];
                                res_next.key_valid = 1'b1;
                                if (kidx == 6'd0) found_next = 1'b0;
                                if (kidx == 6'(KEY_BYTES - 1)) found_next = 1'b1;
                            end
                        end
                        if (count_reg < MIN_SHARE_LEN) count_next = count_reg + 6'd1;
                        left_next = left_dec;
                        if (left_dec == 16'd0) begin
                            count_next = '0;
                            phase_next = (area_dec >= 16'd4) ? BP_HDR : BP_IDLE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        if (entry.last) begin
            res_next.done_res = 1'b1;
            if (entry.mal)       res_next.status = STATUS_BAD;
            else if (found_next) res_next.status = STATUS_FOUND;
            else                 res_next.status = STATUS_NO_KEY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= BP_WAIT;
            count_reg   <= '0;
            area_reg    <= '0;
            type_reg    <= '0;
            left_reg    <= '0;
            klen_reg    <= '0;
            found_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (pop) begin
                out_vld_reg <= 1'b1;
                if (entry.last) begin
                    phase_reg <= BP_WAIT;
                    count_reg <= '0;
                    area_reg  <= '0;
                    type_reg  <= '0;
                    left_reg  <= '0;
                    klen_reg  <= '0;
                    found_reg <= 1'b0;
                end else begin
                    phase_reg <= phase_next;
                    count_reg <= count_next;
                    area_reg  <= area_next;
                    type_reg  <= type_next;
                    left_reg  <= left_next;
                    klen_reg  <= klen_next;
                    found_reg <= found_next;
                end
            end else if (out_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) res_reg <= res_next;
    end

endmodule

FILE: hw/rtl/server_hello_key_share_parser_unit.sv
// ServerHello key share parser: byte stream in, one result beat per byte out.
//
// Input channel s_*: one body byte of a ServerHello handshake message per beat,
// s_tlast on the final byte. Output channel m_*: exactly one beat per input
// byte, in order. m_tuser marks a beat carrying a server key byte (index in
// m_tdata); m_tlast marks the result of the final body byte, whose status
// field says key found, malformed hello or no key share.
// An input beat is held in the two-entry queue behind the front classifier, then
// in the back walker's output register before it reaches the output channel.
// Throughput is one byte per cycle while m_tready stays high; the front and back each hold one counter
// and compare step per byte.
// After reset (aresetn low, synchronous) both parts wait for the first byte of
// a record and the queue is empty. Each s_tlast beat returns both parts to that
// waiting state for the next record.
// When m_tready is low the output beat holds, the queue fills, and s_tready
// drops once both queue entries are taken.
module server_hello_key_share_parser_unit import shkp_pkg::*; #(
    parameter int MAX_BODY_BYTES = 32768
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] key_byte, [12:8] key_index, [14:13] status
    output logic        m_tuser,   // key_valid
    output logic        m_tlast    // done_res
);

    q_entry_t front_entry, head;
    logic     push, pop, q_full, q_not_empty;
    result_t  res;

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    shkp_front #(.MAX_BODY_BYTES(MAX_BODY_BYTES)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .entry     (front_entry)
    );

    shkp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (pop),
        .not_empty  (q_not_empty),
        .head       (head)
    );

    shkp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_not_empty),
        .entry     (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (res)
    );

    assign m_tdata = {1'b0, res.status, res.key_index, res.key_byte};
    assign m_tuser = res.key_valid;
    assign m_tlast = res.done_res;

endmodule

FILE: hw/rtl/shkp_checker.sv
// Port-level checks for the key share parser, bound to the top level.
module shkp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // stalled beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // status only on the closing beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[14:13] == 2'b00)
        else $error("status set on non-final beat");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[14:13] != 2'b11)
        else $error("illegal status code");

    // key fields zero unless a key byte is carried
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[12:0] == 13'd0)
        else $error("key fields set without key byte");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind server_hello_key_share_parser_unit shkp_checker u_shkp_checker (.*);
